>>> src/smeng_pkg.sv
`default_nettype none

package smeng_pkg;

    // fixed field widths
    localparam int IDX_W = 3;
    localparam int POS_W = 4;

    // people handled by the control path (person fields are three bits)
    localparam int LIST_LIMIT = 8;

    // default capacity of the preference stores
    localparam int MAX_PEOPLE_DEFAULT = 8;

    // register map (index taken from paddr[2])
    localparam logic REG_PEOPLE_IN_USE = 1'b0;
    localparam logic [3:0] PEOPLE_RESET = 4'd8;
    localparam logic [3:0] PEOPLE_MIN = 4'd2;

    // request kinds
    localparam logic REQ_PROPOSER = 1'b0;
    localparam logic REQ_RECEIVER = 1'b1;

    // partner slot holding nobody
    localparam logic [POS_W-1:0] PARTNER_NONE = 4'd8;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_INIT,
        ST_PICK,
        ST_PROP,
        ST_CMP,
        ST_OUT
    } state_t;

    // reads issued by the matcher to the preference stores
    typedef struct packed {
        logic             prop_en;
        logic [IDX_W-1:0] prop_row;
        logic [IDX_W-1:0] prop_col;
        logic             rank_en;
        logic [IDX_W-1:0] rank_row;
        logic [IDX_W-1:0] rank_col_new;
        logic [IDX_W-1:0] rank_col_cur;
    } rd_req_t;

    // one result handed to the output register
    typedef struct packed {
        logic             load;
        logic [IDX_W-1:0] receiver;
        logic [IDX_W-1:0] partner;
        logic             paired;
        logic             last;
    } result_t;

endpackage

`default_nettype wire

>>> src/smeng_pref_store.sv
`default_nettype none

module smeng_pref_store #(
    parameter int MAX_PEOPLE = smeng_pkg::MAX_PEOPLE_DEFAULT
) (
    input  wire logic                        aclk,
    input  wire logic                        wr_en,
    input  wire logic                        wr_type,
    input  wire logic [smeng_pkg::IDX_W-1:0] wr_person,
    input  wire logic [smeng_pkg::IDX_W-1:0] wr_position,
    input  wire logic [smeng_pkg::IDX_W-1:0] wr_choice,
    input  wire smeng_pkg::rd_req_t          rd,
    output logic      [smeng_pkg::IDX_W-1:0] prop_choice,
    output logic      [smeng_pkg::IDX_W-1:0] rank_new,
    output logic      [smeng_pkg::IDX_W-1:0] rank_cur
);
    import smeng_pkg::*;

    localparam int DEPTH = MAX_PEOPLE * MAX_PEOPLE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [5:0] MAX_V = 6'(MAX_PEOPLE);

    logic [IDX_W-1:0] plist_mem [DEPTH];
    logic [IDX_W-1:0] rank_mem  [DEPTH];

    logic person_ok;
    logic position_ok;
    logic choice_ok;
    logic plist_we;
    logic rank_we;

    function automatic logic [ADDR_W-1:0] entry_addr(input logic [IDX_W-1:0] row,
                                                     input logic [IDX_W-1:0] col);
        entry_addr = ADDR_W'(int'(row) * MAX_PEOPLE + int'(col));
    endfunction

    // entries outside the store are dropped
    assign person_ok   = {3'b000, wr_person} < MAX_V;
    assign position_ok = {3'b000, wr_position} < MAX_V;
    assign choice_ok   = {3'b000, wr_choice} < MAX_V;
    assign plist_we    = wr_en && (wr_type == REQ_PROPOSER) && person_ok && position_ok;
    assign rank_we     = wr_en && (wr_type == REQ_RECEIVER) && person_ok && choice_ok;

    // proposer lists: receiver named at each position
    always_ff @(posedge aclk) begin
        if (plist_we) begin
            plist_mem[entry_addr(wr_person, wr_position)] <= wr_choice;
        end
        if (rd.prop_en) begin
            prop_choice <= plist_mem[entry_addr(rd.prop_row, rd.prop_col)];
        end
    end

    // receiver rank table, two read ports for the comparison
    always_ff @(posedge aclk) begin
        if (rank_we) begin
            rank_mem[entry_addr(wr_person, wr_choice)] <= wr_position;
        end
        if (rd.rank_en) begin
            rank_new <= rank_mem[entry_addr(rd.rank_row, rd.rank_col_new)];
            rank_cur <= rank_mem[entry_addr(rd.rank_row, rd.rank_col_cur)];
        end
    end

endmodule

`default_nettype wire

>>> src/smeng_match_ctrl.sv
`default_nettype none

module smeng_match_ctrl (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [smeng_pkg::POS_W-1:0] n_used,
    input  wire logic [smeng_pkg::IDX_W-1:0] prop_choice,
    input  wire logic [smeng_pkg::IDX_W-1:0] rank_new,
    input  wire logic [smeng_pkg::IDX_W-1:0] rank_cur,
    input  wire logic                        out_free,
    output logic                             idle,
    output smeng_pkg::rd_req_t               rd,
    output smeng_pkg::result_t               res
);
    import smeng_pkg::*;

    state_t state_reg;
    state_t state_next;

    logic [POS_W-1:0] np_reg      [LIST_LIMIT];
    logic [POS_W-1:0] partner_reg [LIST_LIMIT];
    logic [IDX_W-1:0] queue_reg   [LIST_LIMIT];
    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] tail_reg;
    logic [POS_W-1:0] count_reg;
    logic [IDX_W-1:0] cur_p_reg;
    logic [IDX_W-1:0] cur_r_reg;
    logic [IDX_W-1:0] cur_q_reg;
    logic [IDX_W-1:0] out_idx_reg;

    logic [IDX_W-1:0] q_head;
    logic [POS_W-1:0] np_head;
    logic [IDX_W-1:0] part_rd_idx;
    logic [POS_W-1:0] part_rd;
    logic [IDX_W-1:0] take_r;
    logic             exhausted;
    logic             bad_choice;
    logic             recv_free;
    logic             better;
    logic             out_last;

    logic do_init;
    logic do_issue;
    logic do_rank;
    logic do_take;
    logic do_pop;
    logic do_push;
    logic do_out;

    // lookups into the small state arrays
    assign q_head      = queue_reg[head_reg];
    assign np_head     = np_reg[q_head];
    assign part_rd_idx = (state_reg == ST_OUT) ? out_idx_reg : prop_choice;
    assign part_rd     = partner_reg[part_rd_idx];
    assign take_r      = (state_reg == ST_PROP) ? prop_choice : cur_r_reg;

    // decision terms
    assign exhausted  = np_head >= n_used;
    assign bad_choice = {1'b0, prop_choice} >= n_used;
    assign recv_free  = part_rd == PARTNER_NONE;
    assign better     = rank_new < rank_cur;
    assign out_last   = ({1'b0, out_idx_reg} + 4'd1) == n_used;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (start) state_next = ST_INIT;
            end
            ST_INIT: begin
                state_next = ST_PICK;
            end
            ST_PICK: begin
                if (count_reg == '0) begin
                    state_next = ST_OUT;
                end else if (!exhausted) begin
                    state_next = ST_PROP;
                end
            end
            ST_PROP: begin
                if (bad_choice || recv_free) begin
                    state_next = ST_PICK;
                end else begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                state_next = ST_PICK;
            end
            ST_OUT: begin
                if (out_free && out_last) state_next = ST_LOAD;
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // control outputs
    always_comb begin
        do_init  = 1'b0;
        do_issue = 1'b0;
        do_rank  = 1'b0;
        do_take  = 1'b0;
        do_pop   = 1'b0;
        do_push  = 1'b0;
        do_out   = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
            end
            ST_INIT: begin
                do_init = 1'b1;
            end
            ST_PICK: begin
                if (count_reg != '0) begin
                    if (exhausted) begin
                        do_pop = 1'b1;
                    end else begin
                        do_issue = 1'b1;
                    end
                end
            end
            ST_PROP: begin
                if (!bad_choice) begin
                    if (recv_free) begin
                        do_take = 1'b1;
                        do_pop  = 1'b1;
                    end else begin
                        do_rank = 1'b1;
                    end
                end
            end
            ST_CMP: begin
                if (better) begin
                    do_take = 1'b1;
                    do_pop  = 1'b1;
                    do_push = 1'b1;
                end
            end
            ST_OUT: begin
                do_out = out_free;
            end
            default: begin
            end
        endcase
    end

    assign idle = state_reg == ST_LOAD;

    // memory read requests
    assign rd.prop_en      = do_issue;
    assign rd.prop_row     = q_head;
    assign rd.prop_col     = np_head[IDX_W-1:0];
    assign rd.rank_en      = do_rank;
    assign rd.rank_row     = prop_choice;
    assign rd.rank_col_new = cur_p_reg;
    assign rd.rank_col_cur = part_rd[IDX_W-1:0];

    // result for the output register
    assign res.load     = do_out;
    assign res.receiver = out_idx_reg;
    assign res.partner  = recv_free ? '0 : part_rd[IDX_W-1:0];
    assign res.paired   = !recv_free;
    assign res.last     = out_last;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            out_idx_reg <= '0;
            for (int i = 0; i < LIST_LIMIT; i++) begin
                np_reg[i]      <= '0;
                partner_reg[i] <= PARTNER_NONE;
            end
        end else begin
            state_reg <= state_next;
            if (do_init) begin
                head_reg    <= '0;
                tail_reg    <= n_used[IDX_W-1:0];
                count_reg   <= n_used;
                out_idx_reg <= '0;
                for (int i = 0; i < LIST_LIMIT; i++) begin
                    np_reg[i]      <= '0;
                    partner_reg[i] <= PARTNER_NONE;
                end
            end else begin
                if (do_issue) np_reg[q_head] <= np_head + 4'd1;
                if (do_take) partner_reg[take_r] <= {1'b0, cur_p_reg};
                if (do_pop) head_reg <= head_reg + 3'd1;
                if (do_push) tail_reg <= tail_reg + 3'd1;
                unique case ({do_push, do_pop})
                    2'b01:   count_reg <= count_reg - 4'd1;
                    2'b10:   count_reg <= count_reg + 4'd1;
                    default: count_reg <= count_reg;
                endcase
                if (do_out) out_idx_reg <= out_idx_reg + 3'd1;
            end
        end
    end

    // free queue contents and current proposal
    always_ff @(posedge aclk) begin
        if (do_init) begin
            for (int i = 0; i < LIST_LIMIT; i++) begin
                queue_reg[i] <= IDX_W'(i);
            end
        end else if (do_push) begin
            queue_reg[tail_reg] <= cur_q_reg;
        end
        if (do_issue) cur_p_reg <= q_head;
        if (state_reg == ST_PROP) begin
            cur_r_reg <= prop_choice;
            cur_q_reg <= part_rd[IDX_W-1:0];
        end
    end

    // checks
    a_prop_after_pick: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_PROP |-> $past(state_reg) == ST_PICK)
        else $error("proposal evaluated without a list read");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        do_pop |-> count_reg != '0)
        else $error("pop from empty free queue");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 4'd8)
        else $error("free queue overflow");

    a_issue_head: assert property (@(posedge aclk) disable iff (!aresetn)
        do_issue |=> cur_p_reg == $past(q_head))
        else $error("proposer latch lost the queue head");

endmodule

`default_nettype wire

>>> src/stable_matching_engine.sv
`default_nettype none

// Gale-Shapley stable matching (proposer-optimal). Preference entries are
// taken one per cycle; s_ready is high only while loading. The request that
// carries s_last_entry is stored and then starts matching: a setup step, then
// per free-queue step either retiring an exhausted proposer, or a proposal
// that reads the proposal list memory and, when the receiver is taken, the
// two rank table reads that decide. A matching makes at most n*n proposals
// and retires at most n proposers. Then n results leave, one per cycle as
// m_ready allows, receiver 0 first, the last flagged by m_last_result. The
// stores need no clearing pass; entries never written read back as anything.
// people_in_use is saturated to 2..min(MAX_PEOPLE, 8); the user is to write
// it only while the block is idle, and the block itself does not enforce it.
module stable_matching_engine #(
    parameter int MAX_PEOPLE = smeng_pkg::MAX_PEOPLE_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // preference entries
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_req_type,
    input  wire logic [2:0]  s_person,
    input  wire logic [2:0]  s_rank_position,
    input  wire logic [2:0]  s_choice,
    input  wire logic        s_last_entry,
    // match results
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [2:0]  m_receiver,
    output logic      [2:0]  m_partner,
    output logic             m_paired,
    output logic             m_last_result,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import smeng_pkg::*;

    localparam int USABLE = (MAX_PEOPLE < LIST_LIMIT) ? MAX_PEOPLE : LIST_LIMIT;
    localparam logic [POS_W-1:0] USABLE_N = POS_W'(USABLE);

    logic [3:0]       people_reg;
    logic [POS_W-1:0] n_used;
    logic             in_take;
    logic             idle;
    logic             out_free;
    rd_req_t          rd;
    result_t          res;
    logic [IDX_W-1:0] prop_choice;
    logic [IDX_W-1:0] rank_new;
    logic [IDX_W-1:0] rank_cur;

    logic             m_valid_reg;
    logic [IDX_W-1:0] m_receiver_reg;
    logic [IDX_W-1:0] m_partner_reg;
    logic             m_paired_reg;
    logic             m_last_reg;

    // register port
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            people_reg <= PEOPLE_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_PEOPLE_IN_USE) begin
            people_reg <= pwdata[3:0];
        end
    end
    assign prdata = (paddr[2] == REG_PEOPLE_IN_USE) ? {28'd0, people_reg} : 32'd0;

    // saturated group size
    always_comb begin
        if (people_reg < PEOPLE_MIN) begin
            n_used = PEOPLE_MIN;
        end else if (people_reg > USABLE_N) begin
            n_used = USABLE_N;
        end else begin
            n_used = people_reg;
        end
    end

    assign s_ready  = idle;
    assign in_take  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    smeng_pref_store #(
        .MAX_PEOPLE(MAX_PEOPLE)
    ) u_store (
        .aclk        (aclk),
        .wr_en       (in_take),
        .wr_type     (s_req_type),
        .wr_person   (s_person),
        .wr_position (s_rank_position),
        .wr_choice   (s_choice),
        .rd          (rd),
        .prop_choice (prop_choice),
        .rank_new    (rank_new),
        .rank_cur    (rank_cur)
    );

    smeng_match_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (in_take && s_last_entry),
        .n_used      (n_used),
        .prop_choice (prop_choice),
        .rank_new    (rank_new),
        .rank_cur    (rank_cur),
        .out_free    (out_free),
        .idle        (idle),
        .rd          (rd),
        .res         (res)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res.load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.load) begin
            m_receiver_reg <= res.receiver;
            m_partner_reg  <= res.partner;
            m_paired_reg   <= res.paired;
            m_last_reg     <= res.last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_receiver    = m_receiver_reg;
    assign m_partner     = m_partner_reg;
    assign m_paired      = m_paired_reg;
    assign m_last_result = m_last_reg;

endmodule

`default_nettype wire

>>> test/stable_matching_engine_tb.sv
`timescale 1ns / 100ps

module stable_matching_engine_tb;
    import smeng_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int NOBODY = int'(PARTNER_NONE);

    // one preference request; typed marks a directed row whose pairings are listed below
    typedef struct packed {
        logic       req_type;
        logic [2:0] person;
        logic [2:0] rank_pos;
        logic [2:0] choice;
        logic       last;
        logic       typed;
    } pref_req_t;

    // one receiver pairing as the block reports it
    typedef struct packed {
        logic [2:0] receiver;
        logic [2:0] partner;
        logic       paired;
        logic       last;
    } pairing_t;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_RANDOM,
        READY_PATTERN
    } ready_mode_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_req_type = 1'b0;
    logic [2:0]  s_person = 3'd0;
    logic [2:0]  s_rank_position = 3'd0;
    logic [2:0]  s_choice = 3'd0;
    logic        s_last_entry = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_receiver;
    logic [2:0]  m_partner;
    logic        m_paired;
    logic        m_last_result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // predictor copy of the block's tables and register
    logic [2:0]  pref_list [8][8];
    logic [2:0]  rank_tab [8][8];
    logic [3:0]  people_raw = PEOPLE_RESET;

    // entries already planned, so a matching never reads an unwritten entry
    bit          list_planned [8][8];
    bit          rank_planned [8][8];

    pref_req_t   request_q [$];
    pairing_t    pairing_q [$];
    pairing_t    typed_pairings [$];
    pref_req_t   directed_tab [22];
    pref_req_t   next_req;
    pairing_t    want;
    pairing_t    typed_want;
    logic        cur_typed = 1'b0;

    int          burst_left = 1;
    int          gap_left = 0;
    ready_mode_t ready_mode = READY_ALWAYS;
    int          ready_span = 0;
    logic [7:0]  ready_mask = 8'hff;
    int          sent_cnt = 0;
    int          mismatch_cnt = 0;
    int          cycle_cnt = 0;

    stable_matching_engine u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_person       (s_person),
        .s_rank_position(s_rank_position),
        .s_choice       (s_choice),
        .s_last_entry   (s_last_entry),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_receiver     (m_receiver),
        .m_partner      (m_partner),
        .m_paired       (m_paired),
        .m_last_result  (m_last_result),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #4 aclk = ~aclk;

    // saturate the register value into the usable range
    function automatic int people_count(input logic [3:0] raw);
        if (raw < PEOPLE_MIN) return int'(PEOPLE_MIN);
        if (raw > LIST_LIMIT) return LIST_LIMIT;
        return int'(raw);
    endfunction

    function automatic bit tables_ready(input int n);
        int i;
        int j;
        for (i = 0; i < n; i++) begin
            for (j = 0; j < n; j++) begin
                if (!list_planned[i][j] || !rank_planned[i][j]) return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // proposer-optimal matching over the stored tables, one pairing per receiver
    function automatic void predict_pairings();
        int n;
        int i;
        int p;
        int r;
        int q;
        int next_pos [8];
        int mate [8];
        int free_q [$];
        pairing_t res;
        n = people_count(people_raw);
        for (i = 0; i < 8; i++) begin
            next_pos[i] = 0;
            mate[i] = NOBODY;
        end
        for (i = 0; i < n; i++) free_q.push_back(i);
        while (free_q.size() > 0) begin
            p = free_q[0];
            // exhausted list leaves the queue unmatched
            if (next_pos[p] >= n) begin
                void'(free_q.pop_front());
                continue;
            end
            r = int'(pref_list[p][next_pos[p]]);
            next_pos[p]++;
            // naming a receiver outside the set counts as a rejection
            if (r >= n) continue;
            q = mate[r];
            if (q == NOBODY) begin
                mate[r] = p;
                void'(free_q.pop_front());
            end else if (rank_tab[r][p] < rank_tab[r][q]) begin
                mate[r] = p;
                void'(free_q.pop_front());
                free_q.push_back(q);
            end
        end
        for (i = 0; i < n; i++) begin
            res.receiver = i[2:0];
            res.partner  = (mate[i] != NOBODY) ? mate[i][2:0] : 3'd0;
            res.paired   = (mate[i] != NOBODY);
            res.last     = (i == n - 1);
            pairing_q.push_back(res);
        end
    endfunction

    // queue one preference request and note which table entry it fills
    task automatic send_entry(input logic kind, input logic [2:0] who, input logic [2:0] at,
                              input logic [2:0] pick, input logic last, input logic typed);
        pref_req_t e;
        e = '{kind, who, at, pick, last, typed};
        if (kind == REQ_PROPOSER) list_planned[who][at] = 1'b1;
        else rank_planned[who][pick] = 1'b1;
        request_q.push_back(e);
        sent_cnt++;
    endtask

    // register write: setup then access phase
    task automatic write_people(input logic [3:0] raw);
        logic [31:0] rnd;
        rnd = $urandom();
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_PEOPLE_IN_USE, 2'b00};
        pwdata  <= {rnd[31:4], raw};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        people_raw = raw;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // wait until every request went out and every pairing came back
    task automatic wait_idle(input int settle);
        while (request_q.size() != 0 || s_valid || pairing_q.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    // one matching round: list rewrites and noise, fill the gaps, then the last entry
    task automatic run_phase(input int n);
        int lists;
        int sel;
        int who;
        int kind;
        int j;
        int k;
        int t;
        int cnt;
        int perm [8];
        lists = $urandom_range(1, n);
        for (k = 0; k < lists; k++) begin
            sel  = $urandom_range(0, 99);
            who  = $urandom_range(0, n - 1);
            kind = $urandom_range(0, 1);
            if (sel < 85) begin
                for (j = 0; j < n; j++) perm[j] = j;
                for (j = n - 1; j > 0; j--) begin
                    t = $urandom_range(0, j);
                    {perm[j], perm[t]} = {perm[t], perm[j]};
                end
                // repeated picks give ties and short lists
                if (sel >= 60) begin
                    for (j = 0; j < n; j++) perm[j] = $urandom_range(0, n - 1);
                end
                // out-of-set receiver in a proposer list
                if (kind == REQ_PROPOSER && n < 8 && $urandom_range(0, 3) == 0)
                    perm[$urandom_range(0, n - 1)] = $urandom_range(n, 7);
                for (j = 0; j < n; j++)
                    send_entry(1'(kind), 3'(who), 3'(j), 3'(perm[j]), 1'b0, 1'b0);
            end else begin
                // noise, with an early last entry once the tables are complete
                cnt = $urandom_range(1, 3);
                for (j = 0; j < cnt; j++)
                    send_entry(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                               3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                               tables_ready(n) && $urandom_range(0, 3) == 0, 1'b0);
            end
        end
        for (k = 0; k < n; k++) begin
            for (j = 0; j < n; j++) begin
                if (!list_planned[k][j])
                    send_entry(REQ_PROPOSER, 3'(k), 3'(j), 3'($urandom_range(0, n - 1)),
                               1'b0, 1'b0);
                if (!rank_planned[k][j])
                    send_entry(REQ_RECEIVER, 3'(k), 3'($urandom_range(0, n - 1)), 3'(j),
                               1'b0, 1'b0);
            end
        end
        send_entry(1'($urandom_range(0, 1)), 3'($urandom_range(0, n - 1)),
                   3'($urandom_range(0, n - 1)), 3'($urandom_range(0, n - 1)), 1'b1, 1'b0);
    endtask

    // request sender in bursts, predictor update on every accepted request
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            burst_left = 1;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                if (s_req_type == REQ_PROPOSER) pref_list[s_person][s_rank_position] = s_choice;
                else rank_tab[s_person][s_choice] = s_rank_position;
                if (s_last_entry) begin
                    if (cur_typed) begin
                        do begin
                            typed_want = typed_pairings.pop_front();
                            pairing_q.push_back(typed_want);
                        end while (!typed_want.last);
                    end else begin
                        predict_pairings();
                    end
                end
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0 || request_q.size() == 0) begin
                    s_valid <= 1'b0;
                    if (gap_left > 0) gap_left--;
                end else begin
                    next_req = request_q.pop_front();
                    s_valid         <= 1'b1;
                    s_req_type      <= next_req.req_type;
                    s_person        <= next_req.person;
                    s_rank_position <= next_req.rank_pos;
                    s_choice        <= next_req.choice;
                    s_last_entry    <= next_req.last;
                    cur_typed = next_req.typed;
                    burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // result side stalls: always ready, random, or a rotating mask
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            ready_span = 0;
        end else begin
            if (ready_span == 0) begin
                ready_mode = ready_mode_t'($urandom_range(0, 2));
                ready_span = $urandom_range(8, 64);
                ready_mask = 8'($urandom());
            end else begin
                ready_span--;
            end
            case (ready_mode)
                READY_ALWAYS: begin
                    m_ready <= 1'b1;
                end
                READY_RANDOM: begin
                    m_ready <= ($urandom_range(0, 2) != 0);
                end
                default: begin
                    m_ready <= ready_mask[0];
                    ready_mask = {ready_mask[0], ready_mask[7:1]};
                end
            endcase
        end
    end

    // compare each pairing with the oldest one predicted
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pairing_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected pairing: receiver %0d partner %0d paired %0d last %0d",
                             m_receiver, m_partner, m_paired, m_last_result);
            end else begin
                want = pairing_q.pop_front();
                if (m_receiver !== want.receiver || m_partner !== want.partner ||
                    m_paired !== want.paired || m_last_result !== want.last) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("pairing mismatch: expected r%0d p%0d paired %0d last %0d, %s",
                                 want.receiver, want.partner, want.paired, want.last,
                                 $sformatf("got r%0d p%0d paired %0d last %0d", m_receiver,
                                           m_partner, m_paired, m_last_result));
                end
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int i;
        int phase_no;
        logic [3:0] raw;
        logic [3:0] raw_plan [11];
        raw_plan = '{4'd3, 4'd1, 4'd5, 4'd15, 4'd9, 4'd6, 4'd2, 4'd4, 4'd8, 4'd7, 4'd0};

        // directed requests at two people
        directed_tab = '{
            // every list entry names a receiver outside the set: nobody pairs
            '{REQ_PROPOSER, 3'd0, 3'd0, 3'd7, 1'b0, 1'b0},
            '{REQ_PROPOSER, 3'd0, 3'd1, 3'd2, 1'b0, 1'b0},
            '{REQ_PROPOSER, 3'd1, 3'd0, 3'd7, 1'b0, 1'b0},
            '{REQ_PROPOSER, 3'd1, 3'd1, 3'd3, 1'b0, 1'b0},
            '{REQ_RECEIVER, 3'd0, 3'd0, 3'd0, 1'b0, 1'b0},
            '{REQ_RECEIVER, 3'd0, 3'd1, 3'd1, 1'b0, 1'b0},
            '{REQ_RECEIVER, 3'd1, 3'd0, 3'd1, 1'b0, 1'b0},
            '{REQ_RECEIVER, 3'd1, 3'd1, 3'd0, 1'b1, 1'b1},
            // both propose to receiver 0 first, which swaps to proposer 1
            '{REQ_PROPOSER, 3'd0, 3'd0, 3'd0, 1'b0, 1'b0},
            '{REQ_PROPOSER, 3'd0, 3'd1, 3'd1, 1'b0, 1'b0},
            '{REQ_PROPOSER, 3'd1, 3'd0, 3'd0, 1'b0, 1'b0},
            '{REQ_PROPOSER, 3'd1, 3'd1, 3'd1, 1'b0, 1'b0},
            '{REQ_RECEIVER, 3'd0, 3'd1, 3'd0, 1'b0, 1'b0},
            '{REQ_RECEIVER, 3'd0, 3'd0, 3'd1, 1'b1, 1'b0},
            // equal ranks at receiver 0 keep the first partner; rerun on kept tables
            '{REQ_RECEIVER, 3'd0, 3'd0, 3'd0, 1'b1, 1'b0},
            // field extremes outside the set in use
            '{REQ_PROPOSER, 3'd7, 3'd7, 3'd7, 1'b0, 1'b0},
            '{REQ_RECEIVER, 3'd7, 3'd7, 3'd7, 1'b0, 1'b0},
            '{REQ_PROPOSER, 3'd5, 3'd3, 3'd4, 1'b0, 1'b0},
            '{REQ_RECEIVER, 3'd6, 3'd2, 3'd5, 1'b0, 1'b0},
            // both want receiver 1 only: proposer 0 runs out of list
            '{REQ_PROPOSER, 3'd0, 3'd0, 3'd1, 1'b0, 1'b0},
            '{REQ_PROPOSER, 3'd1, 3'd0, 3'd1, 1'b0, 1'b0},
            '{REQ_RECEIVER, 3'd1, 3'd0, 3'd1, 1'b1, 1'b0}
        };
        typed_pairings.push_back('{3'd0, 3'd0, 1'b0, 1'b0});
        typed_pairings.push_back('{3'd1, 3'd0, 1'b0, 1'b1});

        // reset
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, register below the minimum
        write_people(4'd0);
        for (i = 0; i < 22; i++)
            send_entry(directed_tab[i].req_type, directed_tab[i].person, directed_tab[i].rank_pos,
                       directed_tab[i].choice, directed_tab[i].last, directed_tab[i].typed);

        // random matching rounds, register changed between rounds
        phase_no = 0;
        while (sent_cnt < 210) begin
            raw = (phase_no < 11) ? raw_plan[phase_no] : 4'($urandom_range(0, 15));
            wait_idle(16);
            write_people(raw);
            run_phase(people_count(raw));
            phase_no++;
        end

        // drain
        wait_idle(40);
        if (mismatch_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
